@@ hdl/uuid_text_parser_top_macros.svh @@
// ---------------------------------------------------------------------------
// UUID text parser assertion macros
// Shared assertion shorthands for the parser's checker.
// ---------------------------------------------------------------------------
`ifndef UUID_TEXT_PARSER_TOP_MACROS_SVH
`define UUID_TEXT_PARSER_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk_i, held off during reset
`define UTP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("uuid_text_parser: same-cycle check failed");

// Next-cycle implication, clocked on clk_i, held off during reset
`define UTP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("uuid_text_parser: next-cycle check failed");

`endif

@@ hdl/utp_pkg.sv @@
// ---------------------------------------------------------------------------
// UUID text parser package
// Widths, status codes, dash slots and the hex digit decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package utp_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned HalfW   = 64;
  localparam int unsigned StatusW = 3;
  localparam int unsigned PosW    = 6;
  localparam int unsigned UuidLen = 36;

  // status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK      = 3'd0,
    ST_DASH    = 3'd1,
    ST_HEX     = 3'd2,
    ST_VERSION = 3'd3,
    ST_VARIANT = 3'd4
  } status_e;

  localparam logic [PosW-1:0]  LastPos  = PosW'(UuidLen - 1);
  localparam logic [PosW-1:0]  DashPos0 = 6'd8;
  localparam logic [PosW-1:0]  DashPos1 = 6'd13;
  localparam logic [PosW-1:0]  DashPos2 = 6'd18;
  localparam logic [PosW-1:0]  DashPos3 = 6'd23;
  localparam logic [CharW-1:0] DashChar = 8'h2d;

  localparam logic [3:0] VersionFour = 4'h4;
  localparam logic [1:0] VariantRfc  = 2'b10;

  // decoded character: nibble and a flag for a valid hex digit
  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_dec_t;

  function automatic hex_dec_t hex_decode(input logic [CharW-1:0] c);
    hex_dec_t r;
    logic [CharW-1:0] d;
    r = '0;
    d = '0;
    if (c inside {[8'h30:8'h39]}) begin
      d = c - 8'h30;
      r.ok = 1'b1;
      r.nib = d[3:0];
    end else if (c inside {[8'h41:8'h46]}) begin
      d = c - 8'h37;
      r.ok = 1'b1;
      r.nib = d[3:0];
    end else if (c inside {[8'h61:8'h66]}) begin
      d = c - 8'h57;
      r.ok = 1'b1;
      r.nib = d[3:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/uuid_text_parser_top.sv @@
// ---------------------------------------------------------------------------
// UUID text parser
// Parses a 36-character UUID string, one character a beat, into two 64-bit
// halves and a status after the last character.
// ---------------------------------------------------------------------------
//  Channel   | Dir | tdata                         | tuser
//  s_axis    | in  | [7:0] text_char               | -
//  m_axis    | out | [63:0] high_half,             | [2:0] status
//            |     | [127:64] low_half             |
//
//  One character is taken every cycle, but the 36th waits while a result is
//  held back; the position counter and digit accumulator update in the same
//  cycle a beat is accepted. The result register loads on the edge that takes
//  the 36th character, so the result beat is offered from the next cycle on.
//  A stalled result only blocks the 36th character of the next string.
//  Reset clears position, faults, accumulator and the result valid flag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module uuid_text_parser_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // s_axis_tdata: [7:0] text_char
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [utp_pkg::CharW-1:0]             s_axis_tdata,
  // m_axis_tdata: [63:0] high_half, [127:64] low_half
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [2*utp_pkg::HalfW-1:0]           m_axis_tdata,
  // m_axis_tuser: [2:0] status
  output logic [utp_pkg::StatusW-1:0]           m_axis_tuser
);
  import utp_pkg::*;

  logic [PosW-1:0]    pos_q, pos_d;
  logic [2*HalfW-1:0] acc_q, acc_d;
  logic               dash_flt_q, dash_flt_d;
  logic               hex_flt_q, hex_flt_d;
  logic               out_vld_q, out_vld_d;
  logic [2*HalfW-1:0] out_acc_q, out_acc_d;
  status_e            out_st_q, out_st_d;

  logic     in_beat;
  logic     last_char;
  logic     dash_slot;
  hex_dec_t dec;
  logic     out_free;

  assign last_char = (pos_q == LastPos);
  assign out_free  = !out_vld_q || m_axis_tready;
  // only the closing character needs room in the result register
  assign s_axis_tready = !last_char || out_free;
  assign in_beat = s_axis_tvalid && s_axis_tready;

  assign dash_slot = (pos_q == DashPos0) || (pos_q == DashPos1) ||
                     (pos_q == DashPos2) || (pos_q == DashPos3);
  assign dec = hex_decode(s_axis_tdata);

  // character step and end-of-string result
  always_comb begin
    logic [2*HalfW-1:0] acc_nx;
    logic               dash_nx;
    logic               hex_nx;
    acc_nx  = acc_q;
    dash_nx = dash_flt_q;
    hex_nx  = hex_flt_q;
    if (dash_slot) begin
      if (s_axis_tdata != DashChar) dash_nx = 1'b1;
    end else begin
      if (!dec.ok) hex_nx = 1'b1;
      acc_nx = {acc_q[2*HalfW-5:0], dec.nib};
    end

    pos_d      = pos_q;
    acc_d      = acc_q;
    dash_flt_d = dash_flt_q;
    hex_flt_d  = hex_flt_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_acc_d  = out_acc_q;
    out_st_d   = out_st_q;

    if (in_beat) begin
      if (last_char) begin
        pos_d      = '0;
        acc_d      = '0;
        dash_flt_d = 1'b0;
        hex_flt_d  = 1'b0;
        out_vld_d  = 1'b1;
        out_acc_d  = acc_nx;
        if (dash_nx)                                   out_st_d = ST_DASH;
        else if (hex_nx)                               out_st_d = ST_HEX;
        else if (acc_nx[HalfW+15:HalfW+12] != VersionFour) out_st_d = ST_VERSION;
        else if (acc_nx[HalfW-1:HalfW-2] != VariantRfc)    out_st_d = ST_VARIANT;
        else                                           out_st_d = ST_OK;
      end else begin
        pos_d      = pos_q + PosW'(1);
        acc_d      = acc_nx;
        dash_flt_d = dash_nx;
        hex_flt_d  = hex_nx;
      end
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      acc_q      <= '0;
      dash_flt_q <= 1'b0;
      hex_flt_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      acc_q      <= acc_d;
      dash_flt_q <= dash_flt_d;
      hex_flt_q  <= hex_flt_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_acc_q <= out_acc_d;
    out_st_q  <= out_st_d;
  end

  // low half sits above the high half in tdata
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_acc_q[HalfW-1:0], out_acc_q[2*HalfW-1:HalfW]};
  assign m_axis_tuser  = out_st_q;

endmodule

@@ hdl/utp_checker.sv @@
// ---------------------------------------------------------------------------
// UUID text parser checker
// Port-level checks on result beats and input stalls, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "uuid_text_parser_top_macros.svh"

module utp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [2*utp_pkg::HalfW-1:0] m_axis_tdata,
  input logic [utp_pkg::StatusW-1:0] m_axis_tuser
);
  import utp_pkg::*;

  logic ver_ok;
  logic var_ok;

  // version nibble of the high half, variant bits of the low half
  assign ver_ok = (m_axis_tdata[15:12] == VersionFour);
  assign var_ok = (m_axis_tdata[127:126] == VariantRfc);

  // a stalled result beat stays up
  `UTP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  // a good result carries version four and the RFC variant
  `UTP_ASSERT_NOW(a_ok_fields, m_axis_tvalid && (m_axis_tuser == ST_OK), ver_ok && var_ok)

  // a version fault really has a wrong version nibble
  `UTP_ASSERT_NOW(a_ver_fault, m_axis_tvalid && (m_axis_tuser == ST_VERSION), !ver_ok)

  // a variant fault has the right version and a wrong variant
  `UTP_ASSERT_NOW(a_var_fault, m_axis_tvalid && (m_axis_tuser == ST_VARIANT), ver_ok && !var_ok)

  // input stalls only when a result is held back
  `UTP_ASSERT_NOW(a_in_stall, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

endmodule

bind uuid_text_parser_top utp_checker u_utp_checker (.*);
